// ===== src/text_token_lexer_defines.svh =====
// Assertion macros for the text token lexer checker
`ifndef TEXT_TOKEN_LEXER_DEFINES_SVH
`define TEXT_TOKEN_LEXER_DEFINES_SVH

// same-cycle implication, off while in reset
`define TKL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("text_token_lexer: check failed");

// next-cycle implication, off while in reset
`define TKL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text_token_lexer: check failed");

`endif

// ===== src/tkl_pkg.sv =====
// Types, constants and helpers shared by the text token lexer modules
`timescale 1ns / 1ps

package tkl_pkg;

  localparam int LINE_BITS  = 16;
  localparam int OUT_LINE_W = 16;
  localparam int MAX_RES    = 3;
  localparam int RES_CNT_W  = 2;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;
  localparam int CFG_AW     = 3;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam logic [7:0] MAX_LEN_RST = 8'd63;

  // register index taken from the word address bit
  localparam logic REG_MAX_TOKEN_LEN = 1'b0;

  typedef enum logic [6:0] {
    M_IDLE    = 7'b0000001,
    M_SLASH   = 7'b0000010,
    M_COMMENT = 7'b0000100,
    M_PLAIN   = 7'b0001000,
    M_DQUOTE  = 7'b0010000,
    M_SQUOTE  = 7'b0100000,
    M_ENDED   = 7'b1000000
  } mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       token_done;
  } res_t;

  typedef struct packed {
    logic [7:0]            ch;
    logic                  has_char;
    logic                  token_done;
    logic [OUT_LINE_W-1:0] line;
  } ent_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] len;
    logic       line_inc;
  } scan_upd_t;

  function automatic logic is_space(input logic [7:0] c);
    return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
  endfunction

endpackage

// ===== src/text_token_lexer.sv =====
// Top level of the streaming text token lexer
`timescale 1ns / 1ps

// One text byte is taken per cycle while the result queue holds at most one
// result. Each byte is decoded against the scan state combinationally and
// its zero to three results are written to a four-entry result queue, which
// hands out one result per cycle while the output is not stalled. A stream
// of bytes that give one result or none thus runs at one byte per cycle
// unless the output stalls; a byte that gives two or three results stalls
// the input until the queue has drained back to one entry. Results are
// registered in the queue before they reach the output. Tokens are split
// on whitespace, line comments are dropped, quotes are stripped, and every
// result carries the line count as it stood when its byte arrived.
module text_token_lexer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_ch,
  input  logic                          in_end_of_text,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_out_char,
  output logic                          out_has_char,
  output logic                          out_token_done,
  output logic [15:0]                   out_line_number,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tkl_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import tkl_pkg::*;

  mode_t                 mode_r;
  logic [7:0]            len_r;
  logic [LINE_BITS-1:0]  line_r, line_nxt;
  logic [7:0]            max_len_r;
  scan_upd_t             upd;
  res_t [MAX_RES-1:0]    res;
  logic [RES_CNT_W-1:0]  res_cnt;
  logic                  room;
  logic                  accept;
  logic                  cfg_wr;
  ent_t                  out_ent;

  assign in_stall   = !room;
  assign accept     = in_valid && room;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[CFG_AW-1] == REG_MAX_TOKEN_LEN);
  assign cfg_prdata = (cfg_paddr[CFG_AW-1] == REG_MAX_TOKEN_LEN) ?
                      {24'd0, max_len_r} : 32'd0;

  tkl_scan u_scan (
    .mode_i        (mode_r),
    .len_i         (len_r),
    .max_len_i     (max_len_r),
    .ch_i          (in_ch),
    .end_of_text_i (in_end_of_text),
    .upd_o         (upd),
    .res_o         (res),
    .res_cnt_o     (res_cnt)
  );

  tkl_res_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_cnt_i  (accept ? res_cnt : RES_CNT_W'(0)),
    .push_res_i  (res),
    .push_line_i (OUT_LINE_W'(line_r)),
    .room_o      (room),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_ent_o   (out_ent)
  );

  assign out_out_char    = out_ent.ch;
  assign out_has_char    = out_ent.has_char;
  assign out_token_done  = out_ent.token_done;
  assign out_line_number = out_ent.line;

  always_comb begin
    line_nxt = line_r;
    if (upd.line_inc && (line_r != '1)) begin
      line_nxt = line_r + LINE_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_IDLE;
      len_r     <= '0;
      line_r    <= '0;
      max_len_r <= MAX_LEN_RST;
    end else begin
      if (accept) begin
        mode_r <= upd.mode;
        len_r  <= upd.len;
        line_r <= line_nxt;
      end
      if (cfg_wr) begin
        max_len_r <= cfg_pwdata[7:0];
      end
    end
  end

endmodule

// ===== src/tkl_scan.sv =====
// Next-state and result decode for one text byte
`timescale 1ns / 1ps

module tkl_scan (
  input  tkl_pkg::mode_t                     mode_i,
  input  logic [7:0]                         len_i,
  input  logic [7:0]                         max_len_i,
  input  logic [7:0]                         ch_i,
  input  logic                               end_of_text_i,
  output tkl_pkg::scan_upd_t                 upd_o,
  output tkl_pkg::res_t [tkl_pkg::MAX_RES-1:0] res_o,
  output logic [tkl_pkg::RES_CNT_W-1:0]      res_cnt_o
);
  import tkl_pkg::*;

  logic [7:0]           lim;
  logic                 is_sp;
  logic                 eot;
  mode_t                idle_mode;
  logic [7:0]           idle_len;
  logic                 idle_emit;
  logic                 idle_inc;
  logic                 emit_slash;
  logic                 emit_mid;
  logic                 emit_done;
  logic                 run_idle;
  logic [7:0]           quote;
  logic [RES_CNT_W-1:0] n;

  always_comb begin
    lim   = (max_len_i == 8'd0) ? 8'd1 : max_len_i;
    is_sp = is_space(ch_i);
    eot   = end_of_text_i | (ch_i == CH_NUL);
    quote = (mode_i == M_DQUOTE) ? CH_DQUOTE : CH_SQUOTE;

    idle_mode = M_IDLE;
    idle_len  = 8'd0;
    idle_emit = 1'b0;
    idle_inc  = 1'b0;
    if (is_sp) begin
      idle_inc = (ch_i == CH_NL);
    end else if (ch_i == CH_SLASH) begin
      idle_mode = M_SLASH;
    end else if (ch_i == CH_DQUOTE) begin
      idle_mode = M_DQUOTE;
    end else if (ch_i == CH_SQUOTE) begin
      idle_mode = M_SQUOTE;
    end else begin
      idle_mode = M_PLAIN;
      idle_len  = 8'd1;
      idle_emit = 1'b1;
    end

    emit_slash     = 1'b0;
    emit_mid       = 1'b0;
    emit_done      = 1'b0;
    run_idle       = 1'b0;
    upd_o.mode     = mode_i;
    upd_o.len      = len_i;
    upd_o.line_inc = 1'b0;

    if (mode_i == M_ENDED) begin
      upd_o.mode = M_ENDED;
    end else if (eot) begin
      emit_slash = (mode_i == M_SLASH);
      emit_done  = (mode_i == M_SLASH) || (mode_i == M_PLAIN) ||
                   (mode_i == M_DQUOTE) || (mode_i == M_SQUOTE);
      upd_o.mode = M_ENDED;
      upd_o.len  = 8'd0;
    end else begin
      case (mode_i)
        M_SLASH: begin
          if (ch_i == CH_SLASH) begin
            upd_o.mode = M_COMMENT;
          end else begin
            emit_slash = 1'b1;
            if ((lim <= 8'd1) || is_sp) begin
              emit_done = 1'b1;
              run_idle  = 1'b1;
            end else begin
              emit_mid   = 1'b1;
              upd_o.mode = M_PLAIN;
              upd_o.len  = 8'd2;
            end
          end
        end
        M_COMMENT: begin
          if (ch_i == CH_NL) begin
            upd_o.line_inc = 1'b1;
            upd_o.mode     = M_IDLE;
          end
        end
        M_PLAIN: begin
          if ((len_i >= lim) || is_sp) begin
            emit_done = 1'b1;
            run_idle  = 1'b1;
          end else begin
            emit_mid  = 1'b1;
            upd_o.len = len_i + 8'd1;
          end
        end
        M_DQUOTE, M_SQUOTE: begin
          if (len_i >= lim) begin
            emit_done = 1'b1;
            if (ch_i != quote) begin
              run_idle = 1'b1;
            end else begin
              upd_o.mode = M_IDLE;
              upd_o.len  = 8'd0;
            end
          end else if (ch_i == quote) begin
            emit_done  = 1'b1;
            upd_o.mode = M_IDLE;
            upd_o.len  = 8'd0;
          end else begin
            emit_mid  = 1'b1;
            upd_o.len = len_i + 8'd1;
          end
        end
        default: begin
          run_idle = 1'b1;
        end
      endcase
    end

    if (run_idle) begin
      upd_o.mode     = idle_mode;
      upd_o.len      = idle_len;
      upd_o.line_inc = idle_inc;
    end

    res_o = '0;
    n     = '0;
    if (emit_slash) begin
      res_o[n] = '{ch: CH_SLASH, has_char: 1'b1, token_done: 1'b0};
      n        = n + 2'd1;
    end
    if (emit_mid) begin
      res_o[n] = '{ch: ch_i, has_char: 1'b1, token_done: 1'b0};
      n        = n + 2'd1;
    end
    if (emit_done) begin
      res_o[n] = '{ch: CH_NUL, has_char: 1'b0, token_done: 1'b1};
      n        = n + 2'd1;
    end
    if (run_idle && idle_emit) begin
      res_o[n] = '{ch: ch_i, has_char: 1'b1, token_done: 1'b0};
      n        = n + 2'd1;
    end
    res_cnt_o = n;
  end

endmodule

// ===== src/tkl_res_fifo.sv =====
// Result queue: takes up to three results a cycle, hands out one while not stalled
`timescale 1ns / 1ps

module tkl_res_fifo (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [tkl_pkg::RES_CNT_W-1:0]         push_cnt_i,
  input  tkl_pkg::res_t [tkl_pkg::MAX_RES-1:0]  push_res_i,
  input  logic [tkl_pkg::OUT_LINE_W-1:0]        push_line_i,
  output logic                                  room_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output tkl_pkg::ent_t                         out_ent_o
);
  import tkl_pkg::*;

  ent_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic               pop;

  assign out_valid_o = (cnt_r != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign room_o      = (cnt_r <= FIFO_CW'(FIFO_DEPTH - MAX_RES));
  assign out_ent_o   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push_cnt_i);
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
    cnt_nxt    = cnt_r + FIFO_CW'(push_cnt_i) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (RES_CNT_W'(i) < push_cnt_i) begin
        mem_r[wr_ptr_r + FIFO_AW'(i)] <= '{ch:         push_res_i[i].ch,
                                           has_char:   push_res_i[i].has_char,
                                           token_done: push_res_i[i].token_done,
                                           line:       push_line_i};
      end
    end
  end

endmodule

// ===== src/tkl_checker.sv =====
// Port-level checks for the text token lexer, bound to the top level
`timescale 1ns / 1ps
`include "text_token_lexer_defines.svh"

module tkl_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [7:0]                 in_ch,
  input logic                       in_end_of_text,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [7:0]                 out_out_char,
  input logic                       out_has_char,
  input logic                       out_token_done,
  input logic [15:0]                out_line_number,
  input logic                       cfg_psel,
  input logic                       cfg_penable,
  input logic                       cfg_pwrite,
  input logic [tkl_pkg::CFG_AW-1:0] cfg_paddr,
  input logic [31:0]                cfg_pwdata,
  input logic [31:0]                cfg_prdata,
  input logic                       cfg_pready
);

  `TKL_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_out_char) && $stable(out_has_char) && $stable(out_token_done) && $stable(out_line_number))
  `TKL_ASSERT_IMP(a_done_empty, out_valid && out_token_done, !out_has_char && (out_out_char == 8'd0))
  `TKL_ASSERT_IMP(a_kind_set, out_valid && !out_has_char, out_token_done)
  `TKL_ASSERT_IMP(a_char_nonzero, out_valid && out_has_char, out_out_char != 8'd0)

endmodule

bind text_token_lexer tkl_checker u_tkl_checker (.*);
